// ----- sv/keyframe_vec3_interpolator_defines.svh -----
// Assertion macros used by the interpolator RTL file.
`ifndef KEYFRAME_VEC3_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_VEC3_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define KVI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define KVI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kvi_pkg.sv -----
package kvi_pkg;

    // item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_EVAL   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_VALUE    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // component selects for the shared multiply/divide
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // restoring divider: quotient bits per evaluation component
    localparam int DIV_STEPS = 64;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] time_req;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] duration;
    } out_item_t;

    // one stored keyframe
    typedef struct packed {
        logic signed [31:0] key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
    } key_t;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_INS_RD   = 12'b0000_0000_0010,
        S_INS_CHK  = 12'b0000_0000_0100,
        S_EV_RD0   = 12'b0000_0000_1000,
        S_EV_CHK0  = 12'b0000_0001_0000,
        S_EV_RDL   = 12'b0000_0010_0000,
        S_EV_CLAMP = 12'b0000_0100_0000,
        S_EV_RD    = 12'b0000_1000_0000,
        S_EV_CHK   = 12'b0001_0000_0000,
        S_MUL      = 12'b0010_0000_0000,
        S_DIV      = 12'b0100_0000_0000,
        S_ACC      = 12'b1000_0000_0000
    } state_t;

endpackage

// ----- sv/keyframe_vec3_interpolator.sv -----
// Channel   Ports                Handshake
// --------  -------------------  -----------------------------------------
// request   req (in_item_t)      taken at clk edge with start=1, busy=0
// result    rsp (out_item_t)     valid for one cycle while done=1
//
// Insert: each keyframe later than the new one is read and shifted up one
// place, then the new key is written to the freed slot; done follows in the next cycle.
// Evaluate: the first key is read and checked, then each segment scanned, then per
// component a multiply step, 64 divider steps and one accumulate step;
// clamped cases answer from the first or last key without the divider.
// The keyframe RAM's registered read port and the shared serial divider set
// this sequence. Full or empty cases answer in the cycle after start.
// Reset clears the control state and keyframe count, not the table.
// The receiver cannot stall: each result stands for exactly one cycle.
`include "keyframe_vec3_interpolator_defines.svh"

module keyframe_vec3_interpolator #(
    parameter int MAX_KEYS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  kvi_pkg::in_item_t  req,
    output logic               done,
    output kvi_pkg::out_item_t rsp
);
    import kvi_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int SW = $clog2(DIV_STEPS);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] last_reg, last_next;
    logic               done_reg, done_next;

    in_item_t           item_reg, item_next;
    out_item_t          out_reg, out_next;
    logic [AW-1:0]      idx_reg, idx_next;
    key_t               prev_reg, prev_next;
    key_t               cur_reg, cur_next;
    logic [31:0]        span_reg, span_next;
    logic [31:0]        dt_reg, dt_next;
    logic [1:0]         comp_reg, comp_next;
    logic               neg_reg, neg_next;
    logic [63:0]        num_reg, num_next;
    logic [31:0]        rem_reg, rem_next;
    logic [SW-1:0]      step_reg, step_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    key_t               wr_data;
    logic [AW-1:0]      rd_addr;
    key_t               rd_key;
    key_t               new_key;

    logic signed [31:0] v0, v1;
    logic [32:0]        diff, mag;
    logic [64:0]        prod;
    logic [32:0]        rem_sh;
    logic               ge;
    logic [32:0]        acc;
    logic [31:0]        span_w;
    logic               last_ins;

    kvi_ram #(
        .WIDTH ($bits(key_t)),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_key)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = out_reg;

    assign new_key = '{key_time: item_reg.time_req, key_x: item_reg.x_in,
                       key_y: item_reg.y_in, key_z: item_reg.z_in};
    assign last_ins = (CW'(idx_reg) == count_reg);
    assign span_w   = 32'(rd_key.key_time - prev_reg.key_time);

    // component operands for the shared multiplier
    always_comb
    begin
        case (comp_reg)
            COMP_X:
            begin
                v0 = prev_reg.key_x;
                v1 = cur_reg.key_x;
            end
            COMP_Y:
            begin
                v0 = prev_reg.key_y;
                v1 = cur_reg.key_y;
            end
            default:
            begin
                v0 = prev_reg.key_z;
                v1 = cur_reg.key_z;
            end
        endcase
    end

    assign diff = {v1[31], v1} - {v0[31], v0};
    assign mag  = diff[32] ? (33'd0 - diff) : diff;
    assign prod = mag * {33'd0, dt_reg};

    // one restoring divider step
    assign rem_sh = {rem_reg, num_reg[63]};
    assign ge     = (rem_sh >= {1'b0, span_reg});

    // apply the quotient to the left value
    assign acc = neg_reg ? ({v0[31], v0} - num_reg[32:0])
                         : ({v0[31], v0} + num_reg[32:0]);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        last_next  = last_reg;
        done_next  = 1'b0;
        item_next  = item_reg;
        out_next   = out_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        span_next  = span_reg;
        dt_next    = dt_reg;
        comp_next  = comp_reg;
        neg_next   = neg_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = new_key;
        rd_addr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = req;
                    if (req.kind == KIND_INSERT)
                    begin
                        if (count_reg == CW'(MAX_KEYS))
                        begin
                            out_next  = '{ST_FULL, 32'sd0, 32'sd0, 32'sd0, last_reg};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            idx_next   = count_reg[AW-1:0];
                            state_next = S_INS_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_next  = '{ST_EMPTY, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EV_RD0;
                    end
                end
            end
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (last_ins)
                    begin
                        last_next = item_reg.time_req;
                    end
                    out_next   = '{ST_INSERTED, 32'sd0, 32'sd0, 32'sd0,
                                   last_ins ? item_reg.time_req : last_reg};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr    = idx_reg - AW'(1);
                    state_next = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                wr_en = 1'b1;
                if (rd_key.key_time > item_reg.time_req)
                begin
                    // move the larger key up one place
                    wr_data    = rd_key;
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    if (last_ins)
                    begin
                        last_next = item_reg.time_req;
                    end
                    out_next   = '{ST_INSERTED, 32'sd0, 32'sd0, 32'sd0,
                                   last_ins ? item_reg.time_req : last_reg};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EV_RD0:
            begin
                rd_addr    = '0;
                state_next = S_EV_CHK0;
            end
            S_EV_CHK0:
            begin
                prev_next = rd_key;
                if (item_reg.time_req <= rd_key.key_time)
                begin
                    out_next   = '{ST_VALUE, rd_key.key_x, rd_key.key_y, rd_key.key_z,
                                   last_reg};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (item_reg.time_req >= last_reg)
                begin
                    state_next = S_EV_RDL;
                end
                else
                begin
                    idx_next   = AW'(1);
                    state_next = S_EV_RD;
                end
            end
            S_EV_RDL:
            begin
                rd_addr    = AW'(count_reg - CW'(1));
                state_next = S_EV_CLAMP;
            end
            S_EV_CLAMP:
            begin
                out_next   = '{ST_VALUE, rd_key.key_x, rd_key.key_y, rd_key.key_z,
                               last_reg};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_EV_RD:
            begin
                rd_addr    = idx_reg;
                state_next = S_EV_CHK;
            end
            S_EV_CHK:
            begin
                if (item_reg.time_req <= rd_key.key_time)
                begin
                    span_next = span_w;
                    dt_next   = 32'(item_reg.time_req - prev_reg.key_time);
                    if (span_w == 32'd0)
                    begin
                        // zero-width segment: left value
                        out_next   = '{ST_VALUE, prev_reg.key_x, prev_reg.key_y,
                                       prev_reg.key_z, last_reg};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = rd_key;
                        comp_next  = COMP_X;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    prev_next  = rd_key;
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_EV_RD;
                end
            end
            S_MUL:
            begin
                neg_next   = diff[32];
                num_next   = prod[63:0];
                rem_next   = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? 32'(rem_sh - {1'b0, span_reg}) : rem_sh[31:0];
                num_next  = {num_reg[62:0], ge};
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(DIV_STEPS - 1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                case (comp_reg)
                    COMP_X:  out_next.out_x = acc[31:0];
                    COMP_Y:  out_next.out_y = acc[31:0];
                    default: out_next.out_z = acc[31:0];
                endcase
                if (comp_reg == COMP_Z)
                begin
                    out_next.status   = ST_VALUE;
                    out_next.duration = last_reg;
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            last_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        span_reg <= span_next;
        dt_reg   <= dt_next;
        comp_reg <= comp_next;
        neg_reg  <= neg_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    `KVI_ASSERT_NEXT(a_start_progress, start && !busy, busy || done,
        "accepted item neither in progress nor answered")
    `KVI_ASSERT_IMPL(a_insert_count, done && (rsp.status == ST_INSERTED),
        count_reg == CW'($past(count_reg) + CW'(1)), "insert did not grow count")
    `KVI_ASSERT_IMPL(a_zero_values, done && (rsp.status != ST_VALUE),
        (rsp.out_x == 32'sd0) && (rsp.out_y == 32'sd0) && (rsp.out_z == 32'sd0),
        "non-value result carries data")
    `KVI_ASSERT_IMPL(a_div_span, state_reg == S_DIV, span_reg != 32'd0,
        "divider running on zero span")

endmodule

// ----- sv/kvi_ram.sv -----
module kvi_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
